[hdl/html_entity_escaper_macros.svh]
// Assertion macros for the HTML entity escaper.
// Used by the escaper modules; assumes clk and rst_n in scope.
`ifndef HTML_ENTITY_ESCAPER_MACROS_SVH
`define HTML_ENTITY_ESCAPER_MACROS_SVH

// same-cycle implication
`define HESC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hesc assertion failed");

// next-cycle implication
`define HESC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hesc assertion failed");

`endif

[hdl/hesc_pkg.sv]
// Package for the HTML entity escaper: transaction structs, microcode
// format, microcode ROM and byte classification. No dependencies.
package hesc_pkg;

  localparam int CAPACITY = 4096;
  localparam int FILL_W   = $clog2(CAPACITY);
  localparam int POS_W    = 12;
  localparam int UA_W     = 5;
  localparam int LEN_W    = 3;

  typedef logic [UA_W-1:0]  uaddr_t;
  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [LEN_W-1:0] len_t;

  localparam logic OP_ESCAPE = 1'b0;
  localparam logic OP_RESET  = 1'b1;

  // microcode entry points
  localparam uaddr_t UA_NOTE  = uaddr_t'(0);
  localparam uaddr_t UA_PLAIN = uaddr_t'(1);
  localparam uaddr_t UA_AMP   = uaddr_t'(2);
  localparam uaddr_t UA_LT    = uaddr_t'(7);
  localparam uaddr_t UA_GT    = uaddr_t'(11);
  localparam uaddr_t UA_QUOT  = uaddr_t'(15);
  localparam uaddr_t UA_APOS  = uaddr_t'(21);

  typedef struct packed {
    logic       operation;
    logic [7:0] in_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic [POS_W-1:0] position;
    logic             byte_valid;
    logic             last_of_run;
    logic             overflow;
    logic [POS_W-1:0] fill_level;
  } out_t;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_IN,
    SRC_LIT
  } src_t;

  typedef struct packed {
    src_t       src;
    logic [7:0] lit;
    logic       last;
  } ucode_t;

  // sequencer -> datapath
  typedef struct packed {
    logic   active;
    ucode_t word;
  } ctl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic exec;
    logic go_note;
  } stat_t;

  typedef struct packed {
    uaddr_t start;
    len_t   len;
  } cls_t;

  function automatic ucode_t uw(input src_t s, input logic [7:0] b, input logic l);
    ucode_t w;
    w.src  = s;
    w.lit  = b;
    w.last = l;
    return w;
  endfunction

  function automatic ucode_t ucode_rd(input uaddr_t a);
    ucode_t w;
    case (a)
      UA_NOTE:                w = uw(SRC_NONE, 8'h00, 1'b1);
      UA_PLAIN:               w = uw(SRC_IN,   8'h00, 1'b1);
      UA_AMP:                 w = uw(SRC_LIT,  "&",   1'b0);
      uaddr_t'(UA_AMP + 1):   w = uw(SRC_LIT,  "a",   1'b0);
      uaddr_t'(UA_AMP + 2):   w = uw(SRC_LIT,  "m",   1'b0);
      uaddr_t'(UA_AMP + 3):   w = uw(SRC_LIT,  "p",   1'b0);
      uaddr_t'(UA_AMP + 4):   w = uw(SRC_LIT,  ";",   1'b1);
      UA_LT:                  w = uw(SRC_LIT,  "&",   1'b0);
      uaddr_t'(UA_LT + 1):    w = uw(SRC_LIT,  "l",   1'b0);
      uaddr_t'(UA_LT + 2):    w = uw(SRC_LIT,  "t",   1'b0);
      uaddr_t'(UA_LT + 3):    w = uw(SRC_LIT,  ";",   1'b1);
      UA_GT:                  w = uw(SRC_LIT,  "&",   1'b0);
      uaddr_t'(UA_GT + 1):    w = uw(SRC_LIT,  "g",   1'b0);
      uaddr_t'(UA_GT + 2):    w = uw(SRC_LIT,  "t",   1'b0);
      uaddr_t'(UA_GT + 3):    w = uw(SRC_LIT,  ";",   1'b1);
      UA_QUOT:                w = uw(SRC_LIT,  "&",   1'b0);
      uaddr_t'(UA_QUOT + 1):  w = uw(SRC_LIT,  "q",   1'b0);
      uaddr_t'(UA_QUOT + 2):  w = uw(SRC_LIT,  "u",   1'b0);
      uaddr_t'(UA_QUOT + 3):  w = uw(SRC_LIT,  "o",   1'b0);
      uaddr_t'(UA_QUOT + 4):  w = uw(SRC_LIT,  "t",   1'b0);
      uaddr_t'(UA_QUOT + 5):  w = uw(SRC_LIT,  ";",   1'b1);
      UA_APOS:                w = uw(SRC_LIT,  "&",   1'b0);
      uaddr_t'(UA_APOS + 1):  w = uw(SRC_LIT,  "#",   1'b0);
      uaddr_t'(UA_APOS + 2):  w = uw(SRC_LIT,  "3",   1'b0);
      uaddr_t'(UA_APOS + 3):  w = uw(SRC_LIT,  "9",   1'b0);
      uaddr_t'(UA_APOS + 4):  w = uw(SRC_LIT,  ";",   1'b1);
      default:                w = uw(SRC_NONE, 8'h00, 1'b1);
    endcase
    return w;
  endfunction

  function automatic cls_t cls_of(input logic [7:0] b);
    cls_t c;
    case (b)
      "&":     begin c.start = UA_AMP;   c.len = len_t'(5); end
      "<":     begin c.start = UA_LT;    c.len = len_t'(4); end
      ">":     begin c.start = UA_GT;    c.len = len_t'(4); end
      "\"":    begin c.start = UA_QUOT;  c.len = len_t'(6); end
      "'":     begin c.start = UA_APOS;  c.len = len_t'(5); end
      default: begin c.start = UA_PLAIN; c.len = len_t'(1); end
    endcase
    return c;
  endfunction

endpackage

[hdl/hesc_sequencer.sv]
// Microcode sequencer: step counter, ROM lookup and dispatch on accept.
// Depends on hesc_pkg and html_entity_escaper_macros.svh.
`include "html_entity_escaper_macros.svh"

module hesc_sequencer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  hesc_pkg::in_t  in_data,
  input  hesc_pkg::stat_t stat,
  output logic           in_stall,
  output hesc_pkg::ctl_t ctl
);

  logic            active_r, active_nxt;
  hesc_pkg::uaddr_t pc_r, pc_nxt;
  hesc_pkg::ucode_t word;
  hesc_pkg::cls_t  cls;
  logic            accept;

  always_comb begin
    word     = hesc_pkg::ucode_rd(pc_r);
    cls      = hesc_pkg::cls_of(in_data.in_byte);
    in_stall = active_r && !(stat.exec && word.last);
    accept   = in_valid && !in_stall;
    ctl.active = active_r;
    ctl.word   = word;

    active_nxt = active_r;
    pc_nxt     = pc_r;
    if (accept) begin
      active_nxt = 1'b1;
      pc_nxt     = stat.go_note ? hesc_pkg::UA_NOTE : cls.start;
    end else if (stat.exec) begin
      if (word.last) begin
        active_nxt = 1'b0;
      end else begin
        pc_nxt = pc_r + hesc_pkg::uaddr_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pc_r     <= hesc_pkg::UA_NOTE;
    end else begin
      active_r <= active_nxt;
      pc_r     <= pc_nxt;
    end
  end

  `HESC_ASSERT_IMP(a_exec_needs_active, stat.exec, active_r)
  `HESC_ASSERT_NXT(a_mid_step_stays, stat.exec && !word.last, active_r)
  `HESC_ASSERT_NXT(a_step_advance, active_r && !stat.exec && !accept, $stable(pc_r))

endmodule

[hdl/hesc_datapath.sv]
// Datapath: fill counter, sticky overflow, fit check and output register.
// Depends on hesc_pkg and html_entity_escaper_macros.svh.
`include "html_entity_escaper_macros.svh"

module hesc_datapath (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_accept,
  input  hesc_pkg::in_t   in_data,
  input  hesc_pkg::ctl_t  ctl,
  input  logic            out_stall,
  output hesc_pkg::stat_t stat,
  output logic            out_valid,
  output hesc_pkg::out_t  out_data
);

  hesc_pkg::fill_t fill_r, fill_nxt, fill_cur, fill_inc;
  logic            ovf_r, ovf_nxt;
  logic [7:0]      byte_r;
  logic            out_valid_r, out_valid_nxt;
  hesc_pkg::out_t  out_data_r, out_data_nxt;
  hesc_pkg::cls_t  cls;
  logic [hesc_pkg::FILL_W:0] need;
  logic            fits;
  logic            exec;

  always_comb begin
    exec     = ctl.active && (!out_valid_r || !out_stall);
    fill_inc = fill_r + hesc_pkg::fill_t'(1);
    fill_cur = (exec && ctl.word.src != hesc_pkg::SRC_NONE) ? fill_inc : fill_r;
    cls      = hesc_pkg::cls_of(in_data.in_byte);
    need     = {1'b0, fill_cur} + (hesc_pkg::FILL_W + 1)'(cls.len);
    fits     = need < (hesc_pkg::FILL_W + 1)'(hesc_pkg::CAPACITY);

    stat.exec    = exec;
    stat.go_note = (in_data.operation == hesc_pkg::OP_RESET) || ovf_r || !fits;

    fill_nxt = fill_cur;
    ovf_nxt  = ovf_r;
    if (in_accept) begin
      if (in_data.operation == hesc_pkg::OP_RESET) begin
        fill_nxt = '0;
        ovf_nxt  = 1'b0;
      end else if (!fits) begin
        ovf_nxt = 1'b1;
      end
    end

    out_data_nxt             = out_data_r;
    out_data_nxt.last_of_run = ctl.word.last;
    out_data_nxt.overflow    = ovf_r;
    unique case (ctl.word.src)
      hesc_pkg::SRC_IN: begin
        out_data_nxt.out_byte   = byte_r;
        out_data_nxt.position   = hesc_pkg::POS_W'(fill_r);
        out_data_nxt.byte_valid = 1'b1;
        out_data_nxt.fill_level = hesc_pkg::POS_W'(fill_inc);
      end
      hesc_pkg::SRC_LIT: begin
        out_data_nxt.out_byte   = ctl.word.lit;
        out_data_nxt.position   = hesc_pkg::POS_W'(fill_r);
        out_data_nxt.byte_valid = 1'b1;
        out_data_nxt.fill_level = hesc_pkg::POS_W'(fill_inc);
      end
      default: begin
        out_data_nxt.out_byte   = '0;
        out_data_nxt.position   = '0;
        out_data_nxt.byte_valid = 1'b0;
        out_data_nxt.fill_level = hesc_pkg::POS_W'(fill_r);
      end
    endcase

    out_valid_nxt = exec ? 1'b1 : (out_valid_r && out_stall);
    out_valid     = out_valid_r;
    out_data      = out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      byte_r <= in_data.in_byte;
    end
    if (exec) begin
      out_data_r <= out_data_nxt;
    end
  end

  `HESC_ASSERT_IMP(a_no_write_after_ovf, out_valid_r && out_data_r.byte_valid,
                   !out_data_r.overflow)
  `HESC_ASSERT_IMP(a_pos_vs_fill, out_valid_r && out_data_r.byte_valid,
                   out_data_r.fill_level == out_data_r.position + hesc_pkg::POS_W'(1))
  `HESC_ASSERT_IMP(a_ovf_set_on_accept, $rose(ovf_r), $past(in_accept))

endmodule

[hdl/html_entity_escaper.sv]
// HTML entity escaper top level: microcode sequencer plus datapath.
// Depends on hesc_pkg, hesc_sequencer, hesc_datapath.
//
//   channel   valid      stall      payload
//   input     in_valid   in_stall   in_data  (hesc_pkg::in_t)
//   result    out_valid  out_stall  out_data (hesc_pkg::out_t)
//
// One microcode step per cycle unless out_stall holds it, one result per step:
// a plain byte, reset or dropped byte is one ROM step, an entity 4 to 6 ROM steps.
// The next transaction is taken in the cycle of the final step of the current one.
// Result register decouples the sides; out_stall holds the step counter.
// Synchronous active-low reset clears fill length, overflow and control.

module html_entity_escaper (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  hesc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output hesc_pkg::out_t out_data
);

  hesc_pkg::ctl_t  ctl;
  hesc_pkg::stat_t stat;
  logic            in_accept;

  assign in_accept = in_valid && !in_stall;

  hesc_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .stat     (stat),
    .in_stall (in_stall),
    .ctl      (ctl)
  );

  hesc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_data   (in_data),
    .ctl       (ctl),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[tb/tb.sv]
// Self-checking testbench for html_entity_escaper: directed table and
// random traffic, with random idling on both channels.
// Depends on hesc_pkg and the html_entity_escaper RTL.
`timescale 1ns / 1ps

module tb;

  localparam int IDLE_MAX = 18;
  localparam int N_RAND   = 311;
  localparam logic [7:0] MARKUP [5] = '{"&", "<", ">", "\"", "'"};

  typedef struct packed {
    logic           typed;
    hesc_pkg::in_t  item;
    hesc_pkg::out_t res;
  } dir_row_t;

  // typed rows: out_byte, position, byte_valid, last_of_run, overflow, fill_level
  localparam int N_DIR = 19;
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    {1'b1, hesc_pkg::OP_RESET,  8'hFF, 8'h00, 12'd0, 1'b0, 1'b1, 1'b0, 12'd0},
    {1'b1, hesc_pkg::OP_ESCAPE, 8'h00, 8'h00, 12'd0, 1'b1, 1'b1, 1'b0, 12'd1},
    {1'b1, hesc_pkg::OP_ESCAPE, 8'hFF, 8'hFF, 12'd1, 1'b1, 1'b1, 1'b0, 12'd2},
    {1'b0, hesc_pkg::OP_ESCAPE, "&",   35'd0},
    {1'b0, hesc_pkg::OP_ESCAPE, "<",   35'd0},
    {1'b0, hesc_pkg::OP_ESCAPE, ">",   35'd0},
    {1'b0, hesc_pkg::OP_ESCAPE, "\"",  35'd0},
    {1'b0, hesc_pkg::OP_ESCAPE, "'",   35'd0},
    {1'b0, hesc_pkg::OP_ESCAPE, 8'h7F, 35'd0},
    {1'b1, hesc_pkg::OP_RESET,  8'h00, 8'h00, 12'd0, 1'b0, 1'b1, 1'b0, 12'd0},
    {1'b0, hesc_pkg::OP_ESCAPE, "'",   35'd0},
    {1'b0, hesc_pkg::OP_ESCAPE, 8'h25, 35'd0},
    {1'b0, hesc_pkg::OP_ESCAPE, 8'h3D, 35'd0},
    {1'b0, hesc_pkg::OP_ESCAPE, 8'h80, 35'd0},
    {1'b0, hesc_pkg::OP_ESCAPE, 8'h3B, 35'd0},
    {1'b0, hesc_pkg::OP_ESCAPE, 8'h41, 35'd0},
    {1'b1, hesc_pkg::OP_RESET,  "&",   8'h00, 12'd0, 1'b0, 1'b1, 1'b0, 12'd0},
    {1'b0, hesc_pkg::OP_ESCAPE, ">",   35'd0},
    {1'b0, hesc_pkg::OP_ESCAPE, 8'h01, 35'd0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  hesc_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  hesc_pkg::out_t out_data;

  hesc_pkg::out_t escaped_bytes[$];
  int   fill_len = 0;
  bit   ovf_sticky = 1'b0;
  int   errors = 0;
  int   idle_max = IDLE_MAX;
  int   item_cnt = 0;
  int   stall_left = 0;

  html_entity_escaper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic void note_result(logic [7:0] b, int pos, bit v, bit l);
    hesc_pkg::out_t r;
    r.out_byte    = b;
    r.position    = hesc_pkg::POS_W'(pos);
    r.byte_valid  = v;
    r.last_of_run = l;
    r.overflow    = ovf_sticky;
    r.fill_level  = hesc_pkg::POS_W'(fill_len);
    escaped_bytes.push_back(r);
  endfunction

  // buffer write model: entities go in whole or not at all, one slot kept spare
  function automatic void escape_into_buffer(hesc_pkg::in_t d);
    string ent;
    int n;
    logic [7:0] b;
    if (d.operation == hesc_pkg::OP_RESET) begin
      fill_len = 0;
      ovf_sticky = 1'b0;
      note_result(8'h00, 0, 1'b0, 1'b1);
      return;
    end
    if (ovf_sticky) begin
      note_result(8'h00, 0, 1'b0, 1'b1);
      return;
    end
    case (d.in_byte)
      "&":     ent = "&amp;";
      "<":     ent = "&lt;";
      ">":     ent = "&gt;";
      "\"":    ent = "&quot;";
      "'":     ent = "&#39;";
      default: ent = "";
    endcase
    n = (ent.len() == 0) ? 1 : ent.len();
    if (fill_len + n >= hesc_pkg::CAPACITY) begin
      ovf_sticky = 1'b1;
      note_result(8'h00, 0, 1'b0, 1'b1);
      return;
    end
    for (int i = 0; i < n; i++) begin
      b = (ent.len() == 0) ? d.in_byte : ent[i];
      fill_len++;
      note_result(b, fill_len - 1, 1'b1, i == n - 1);
    end
  endfunction

  task automatic push_item(hesc_pkg::in_t d, bit typed = 1'b0, hesc_pkg::out_t res = '0);
    int gap;
    if (item_cnt % 40 == 0) idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
    item_cnt++;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    escape_into_buffer(d);
    if (typed) escaped_bytes[escaped_bytes.size() - 1] = res;
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic check_field(string f, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, f, want, got);
      errors++;
    end
  endtask

  task automatic check_result(hesc_pkg::out_t got);
    hesc_pkg::out_t want;
    if (escaped_bytes.size() == 0) begin
      $display("%0t: unexpected result transaction %p", $time, got);
      errors++;
      return;
    end
    want = escaped_bytes.pop_front();
    check_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
    check_field("position", 16'(want.position), 16'(got.position));
    check_field("byte_valid", 16'(want.byte_valid), 16'(got.byte_valid));
    check_field("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
    check_field("overflow", 16'(want.overflow), 16'(got.overflow));
    check_field("fill_level", 16'(want.fill_level), 16'(got.fill_level));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
        stall_left = $urandom_range(0, idle_max);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  initial begin
    hesc_pkg::in_t d;
    int unsigned sel;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++)
      push_item(DIR_TAB[i].item, DIR_TAB[i].typed, DIR_TAB[i].res);

    repeat (N_RAND) begin
      sel = $urandom_range(0, 99);
      d.operation = (sel < 4) ? hesc_pkg::OP_RESET : hesc_pkg::OP_ESCAPE;
      if (sel >= 4 && sel < 40) d.in_byte = MARKUP[$urandom_range(0, 4)];
      else d.in_byte = 8'($urandom_range(0, 255));
      push_item(d);
    end
    in_valid <= 1'b0;

    while (escaped_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/hesc_pkg.sv
hdl/hesc_sequencer.sv
hdl/hesc_datapath.sv
hdl/html_entity_escaper.sv
tb/tb.sv
